[hdl/bsc_pkg.sv]
// Package for the barometric sensor compensation block.
// Shared widths, register indexes, constants and arithmetic helpers; no dependencies.
package bsc_pkg;

    localparam int DATA_W = 32;
    localparam int CFG_W  = 48;
    localparam int IDX_W  = 3;
    localparam int UP_W   = 19;

    localparam logic [IDX_W-1:0] CFG_OSS      = 3'd0;
    localparam logic [IDX_W-1:0] CFG_SIGNED_A = 3'd1;
    localparam logic [IDX_W-1:0] CFG_UNSIGN_A = 3'd2;
    localparam logic [IDX_W-1:0] CFG_SIGNED_B = 3'd3;
    localparam logic [IDX_W-1:0] CFG_SIGNED_M = 3'd4;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_TEMP_DIV = 2'd1;
    localparam logic [1:0] ST_PRES_DIV = 2'd2;

    localparam logic [31:0] K_B6_OFS   = 32'd4000;
    localparam logic [31:0] K_HALF     = 32'd32768;
    localparam logic [15:0] K_B7_SCALE = 16'd50000;
    localparam logic [31:0] K_P1       = 32'd3038;
    localparam logic [31:0] K_P2       = 32'd7357;
    localparam logic [31:0] K_P3       = 32'd3791;
    localparam logic [15:0] K_T_FAIL   = 16'hFF9C;

    function automatic logic [31:0] asr(input logic [31:0] v, input int unsigned s);
        logic signed [31:0] sv;
        sv = $signed(v);
        return 32'(sv >>> s);
    endfunction

    function automatic logic [31:0] sx16(input logic [15:0] v);
        return {{16{v[15]}}, v};
    endfunction

endpackage

[hdl/bsc_if.sv]
// Valid/ready channel interfaces for raw readings and compensated results.
// Depends on nothing.
interface bsc_in_if;
    logic        valid;
    logic        ready;
    logic [15:0] raw_temp;
    logic [15:0] raw_press_word;
    logic [7:0]  raw_press_xlsb;
    modport source (output valid, raw_temp, raw_press_word, raw_press_xlsb, input ready);
    modport sink   (input valid, raw_temp, raw_press_word, raw_press_xlsb, output ready);
endinterface

interface bsc_out_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] temp_tenths;
    logic signed [31:0] pressure_pa;
    logic [1:0]         status;
    modport source (output valid, temp_tenths, pressure_pa, status, input ready);
    modport sink   (input valid, temp_tenths, pressure_pa, status, output ready);
endinterface

[hdl/bsc_div.sv]
// Pipelined unsigned restoring divider, an input register stage and then one quotient bit per stage, with side payload.
// Standalone; used twice by the compensation top level.
module bsc_div #(
    parameter int W  = 32,
    parameter int PW = 8
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          en,
    input  logic          in_valid,
    input  logic [W-1:0]  num,
    input  logic [W-1:0]  den,
    input  logic [PW-1:0] pay_in,
    output logic          out_valid,
    output logic [W-1:0]  quo,
    output logic [PW-1:0] pay_out
);

    logic          vld_reg [W+1];
    logic [W-1:0]  rem_reg [W+1];
    logic [W-1:0]  num_reg [W+1];
    logic [W-1:0]  den_reg [W+1];
    logic [W-1:0]  quo_reg [W+1];
    logic [PW-1:0] pay_reg [W+1];

    logic [W:0]    trial [W+1];
    logic [W:0]    diff  [W+1];
    logic          ge    [W+1];

    always_comb
    begin
        for (int k = 0; k <= W; k++)
        begin
            trial[k] = '0;
            diff[k]  = '0;
            ge[k]    = 1'b0;
        end
        for (int k = 1; k <= W; k++)
        begin
            trial[k] = {rem_reg[k-1], num_reg[k-1][W-1]};
            diff[k]  = trial[k] - {1'b0, den_reg[k-1]};
            ge[k]    = trial[k] >= {1'b0, den_reg[k-1]};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k <= W; k++)
                vld_reg[k] <= 1'b0;
        end
        else if (en)
        begin
            vld_reg[0] <= in_valid;
            for (int k = 1; k <= W; k++)
                vld_reg[k] <= vld_reg[k-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg[0] <= '0;
            num_reg[0] <= num;
            den_reg[0] <= den;
            quo_reg[0] <= '0;
            pay_reg[0] <= pay_in;
            for (int k = 1; k <= W; k++)
            begin
                rem_reg[k] <= ge[k] ? diff[k][W-1:0] : trial[k][W-1:0];
                num_reg[k] <= {num_reg[k-1][W-2:0], 1'b0};
                den_reg[k] <= den_reg[k-1];
                quo_reg[k] <= {quo_reg[k-1][W-2:0], ge[k]};
                pay_reg[k] <= pay_reg[k-1];
            end
        end
    end

    assign out_valid = vld_reg[W];
    assign quo       = quo_reg[W];
    assign pay_out   = pay_reg[W];

endmodule

[hdl/barometric_sensor_compensation.sv]
// Top level of the barometric sensor compensation pipeline.
// Depends on bsc_pkg, bsc_if and bsc_div.
//
// Takes one raw reading per cycle while the pipeline advances and returns one result
// per reading, in order, via stage s1, the temperature divider, c1..c7, the pressure
// divider, e1..e3 and the output register. Each divider has 33 stages: the first loads
// the operands, each later one yields one quotient bit. The pipeline advances when the
// output register is empty or its result is taken; a stall holds every stage in place.
module barometric_sensor_compensation (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     cfg_we,
    input  logic [bsc_pkg::IDX_W-1:0] cfg_index,
    input  logic [bsc_pkg::CFG_W-1:0] cfg_data,
    bsc_in_if.sink                   in_ch,
    bsc_out_if.source                out_ch
);
    import bsc_pkg::*;

    localparam int P1W = UP_W + DATA_W + 2;
    localparam int P2W = 19;

    logic [1:0]  oss_reg;
    logic [47:0] cal_sa_reg, cal_ua_reg, cal_sm_reg;
    logic [31:0] cal_sb_reg;

    logic [31:0] a1, a2, a3, a4, a5, a6, b1, b2, mc, md;
    logic        en;

    assign a1 = sx16(cal_sa_reg[15:0]);
    assign a2 = sx16(cal_sa_reg[31:16]);
    assign a3 = sx16(cal_sa_reg[47:32]);
    assign a4 = 32'(cal_ua_reg[15:0]);
    assign a5 = 32'(cal_ua_reg[31:16]);
    assign a6 = 32'(cal_ua_reg[47:32]);
    assign b1 = sx16(cal_sb_reg[15:0]);
    assign b2 = sx16(cal_sb_reg[31:16]);
    assign mc = sx16(cal_sm_reg[31:16]);
    assign md = sx16(cal_sm_reg[47:32]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            oss_reg    <= 2'd3;
            cal_sa_reg <= '0;
            cal_ua_reg <= '0;
            cal_sb_reg <= '0;
            cal_sm_reg <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_OSS:      oss_reg    <= cfg_data[1:0];
                CFG_SIGNED_A: cal_sa_reg <= cfg_data;
                CFG_UNSIGN_A: cal_ua_reg <= cfg_data;
                CFG_SIGNED_B: cal_sb_reg <= cfg_data[31:0];
                CFG_SIGNED_M: cal_sm_reg <= cfg_data;
                default:      ;
            endcase
        end
    end

    logic out_vld_reg;
    assign en          = !out_vld_reg || out_ch.ready;
    assign in_ch.ready = en;

    // stage s1: raw pressure and first temperature term
    logic [23:0]     pw24;
    logic [3:0]      up_sh;
    logic            s1_vld_reg;
    logic [UP_W-1:0] s1_up_reg;
    logic [31:0]     s1_x1_reg;

    assign pw24  = {in_ch.raw_press_word, in_ch.raw_press_xlsb};
    assign up_sh = 4'd8 - {2'b00, oss_reg};

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s1_up_reg <= UP_W'(pw24 >> up_sh);
            s1_x1_reg <= asr((32'(in_ch.raw_temp) - a6) * a5, 15);
        end
    end

    // temperature division setup
    logic [31:0] xx, tnum, tnum_mag, tden_mag;
    logic        tzero, tneg;
    logic [P1W-1:0] p1_in, p1_out;
    logic        dv1_vld;
    logic [31:0] dv1_q;

    assign xx       = s1_x1_reg + md;
    assign tzero    = xx == '0;
    assign tnum     = mc << 11;
    assign tnum_mag = tnum[31] ? (32'd0 - tnum) : tnum;
    assign tden_mag = tzero ? 32'd1 : (xx[31] ? (32'd0 - xx) : xx);
    assign tneg     = tnum[31] ^ xx[31];
    assign p1_in    = {s1_up_reg, s1_x1_reg, tzero, tneg};

    bsc_div #(.W(DATA_W), .PW(P1W)) u_tdiv (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .in_valid (s1_vld_reg),
        .num      (tnum_mag),
        .den      (tden_mag),
        .pay_in   (p1_in),
        .out_valid(dv1_vld),
        .quo      (dv1_q),
        .pay_out  (p1_out)
    );

    logic [UP_W-1:0] d1_up;
    logic [31:0]     d1_x1, d1_x2, d1_b5;
    logic            d1_tz, d1_neg;

    assign {d1_up, d1_x1, d1_tz, d1_neg} = p1_out;
    assign d1_x2 = d1_neg ? (32'd0 - dv1_q) : dv1_q;
    assign d1_b5 = d1_x1 + d1_x2;

    // c1..c7: pressure coefficient terms
    logic            c_vld_reg [8];
    logic [15:0]     c_t_reg   [8];
    logic            c_tz_reg  [8];
    logic [UP_W-1:0] c_up_reg  [6];
    logic [31:0] c1_b6_reg;
    logic [31:0] c2_bb_reg, c2_a2_reg, c2_a3_reg;
    logic [31:0] c3_bb_reg, c3_x2_reg, c3_x1_reg;
    logic [31:0] c4_b2_reg, c4_b1_reg, c4_x2_reg, c4_x1_reg;
    logic [31:0] c5_b3_reg, c5_x3_reg;
    logic [31:0] c6_b4_reg, c6_df_reg;
    logic [31:0] c7_b4_reg, c7_b7_reg;
    logic [31:0] c5_x3a, c5_b3, c5_x3b;

    assign c5_x3a = asr(c4_b2_reg, 11) + c4_x2_reg;
    assign c5_b3  = asr((((a1 << 2) + c5_x3a) << oss_reg) + 32'd2, 2);
    assign c5_x3b = asr(c4_x1_reg + asr(c4_b1_reg, 16) + 32'd2, 2);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_vld_reg <= 1'b0;
            for (int k = 1; k < 8; k++)
                c_vld_reg[k] <= 1'b0;
        end
        else if (en)
        begin
            s1_vld_reg   <= in_ch.valid;
            c_vld_reg[1] <= dv1_vld;
            for (int k = 2; k < 8; k++)
                c_vld_reg[k] <= c_vld_reg[k-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            c_t_reg[1]  <= 16'(asr(d1_b5 + 32'd8, 4));
            c_tz_reg[1] <= d1_tz;
            c_up_reg[1] <= d1_up;
            for (int k = 2; k < 8; k++)
            begin
                c_t_reg[k]  <= c_t_reg[k-1];
                c_tz_reg[k] <= c_tz_reg[k-1];
            end
            for (int k = 2; k < 6; k++)
                c_up_reg[k] <= c_up_reg[k-1];
            c1_b6_reg <= d1_b5 - K_B6_OFS;
            c2_bb_reg <= c1_b6_reg * c1_b6_reg;
            c2_a2_reg <= a2 * c1_b6_reg;
            c2_a3_reg <= a3 * c1_b6_reg;
            c3_bb_reg <= asr(c2_bb_reg, 12);
            c3_x2_reg <= asr(c2_a2_reg, 11);
            c3_x1_reg <= asr(c2_a3_reg, 13);
            c4_b2_reg <= b2 * c3_bb_reg;
            c4_b1_reg <= b1 * c3_bb_reg;
            c4_x2_reg <= c3_x2_reg;
            c4_x1_reg <= c3_x1_reg;
            c5_b3_reg <= c5_b3;
            c5_x3_reg <= c5_x3b;
            c6_b4_reg <= a4 * (c5_x3_reg + K_HALF);
            c6_df_reg <= 32'(c_up_reg[5]) - c5_b3_reg;
            c7_b4_reg <= c6_b4_reg >> 15;
            c7_b7_reg <= c6_df_reg * 32'(K_B7_SCALE >> oss_reg);
        end
    end

    // pressure division setup
    logic            pz, pshl;
    logic [31:0]     pnum, pden;
    logic [P2W-1:0]  p2_in, p2_out;
    logic            dv2_vld;
    logic [31:0]     dv2_q;

    assign pz    = c7_b4_reg == '0;
    assign pshl  = !c7_b7_reg[31];
    assign pnum  = pshl ? (c7_b7_reg << 1) : c7_b7_reg;
    assign pden  = pz ? 32'd1 : c7_b4_reg;
    assign p2_in = {c_t_reg[7], c_tz_reg[7], pz, pshl};

    bsc_div #(.W(DATA_W), .PW(P2W)) u_pdiv (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .in_valid (c_vld_reg[7]),
        .num      (pnum),
        .den      (pden),
        .pay_in   (p2_in),
        .out_valid(dv2_vld),
        .quo      (dv2_q),
        .pay_out  (p2_out)
    );

    logic [15:0] d2_t;
    logic        d2_tz, d2_pz, d2_shl;
    assign {d2_t, d2_tz, d2_pz, d2_shl} = p2_out;

    // e1..e3: final pressure correction
    logic        e_vld_reg [4];
    logic [15:0] e_t_reg   [4];
    logic        e_tz_reg  [4];
    logic        e_pz_reg  [4];
    logic [31:0] e_p_reg   [4];
    logic [31:0] e2_sq_reg, e2_m7_reg, e3_x1_reg, e3_x2_reg;
    logic [31:0] e2_s;
    logic [31:0] fin_x1, fin_p;

    assign e2_s   = asr(e_p_reg[1], 8);
    assign fin_x1 = asr(e3_x1_reg, 16);
    assign fin_p  = e_p_reg[3] + asr(fin_x1 + e3_x2_reg + K_P3, 4);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 1; k < 4; k++)
                e_vld_reg[k] <= 1'b0;
            out_vld_reg <= 1'b0;
        end
        else if (en)
        begin
            e_vld_reg[1] <= dv2_vld;
            e_vld_reg[2] <= e_vld_reg[1];
            e_vld_reg[3] <= e_vld_reg[2];
            out_vld_reg  <= e_vld_reg[3];
        end
    end

    logic signed [15:0] t_out_reg;
    logic signed [31:0] p_out_reg;
    logic [1:0]         st_out_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            e_t_reg[1]  <= d2_t;
            e_tz_reg[1] <= d2_tz;
            e_pz_reg[1] <= d2_pz;
            e_p_reg[1]  <= d2_shl ? dv2_q : (dv2_q << 1);
            for (int k = 2; k < 4; k++)
            begin
                e_t_reg[k]  <= e_t_reg[k-1];
                e_tz_reg[k] <= e_tz_reg[k-1];
                e_pz_reg[k] <= e_pz_reg[k-1];
                e_p_reg[k]  <= e_p_reg[k-1];
            end
            e2_sq_reg <= e2_s * e2_s;
            e2_m7_reg <= K_P2 * e_p_reg[1];
            e3_x1_reg <= e2_sq_reg * K_P1;
            e3_x2_reg <= asr(32'd0 - e2_m7_reg, 16);
            priority if (e_tz_reg[3])
            begin
                t_out_reg  <= K_T_FAIL;
                p_out_reg  <= '0;
                st_out_reg <= ST_TEMP_DIV;
            end
            else if (e_pz_reg[3])
            begin
                t_out_reg  <= e_t_reg[3];
                p_out_reg  <= '1;
                st_out_reg <= ST_PRES_DIV;
            end
            else
            begin
                t_out_reg  <= e_t_reg[3];
                p_out_reg  <= fin_p;
                st_out_reg <= ST_OK;
            end
        end
    end

    assign out_ch.valid       = out_vld_reg;
    assign out_ch.temp_tenths = t_out_reg;
    assign out_ch.pressure_pa = p_out_reg;
    assign out_ch.status      = st_out_reg;

endmodule

[test/tb_top.sv]
// Self-checking testbench for barometric_sensor_compensation.
// Drives raw readings over valid/ready, predicts each compensated result in
// behavioral code; depends on bsc_pkg, bsc_if and the RTL.
`timescale 1ns / 1ps

module tb_top;
    import bsc_pkg::*;

    typedef struct packed {
        logic [15:0] raw_temp;
        logic [15:0] press_word;
        logic [7:0]  xlsb;
    } reading_t;

    typedef struct packed {
        logic [15:0] temp;
        logic [31:0] press;
        logic [1:0]  status;
    } comp_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_we = 1'b0;
    logic [IDX_W-1:0] cfg_index = '0;
    logic [CFG_W-1:0] cfg_data = '0;

    bsc_in_if  in_ch ();
    bsc_out_if out_ch ();

    barometric_sensor_compensation dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_ch     (in_ch.sink),
        .out_ch    (out_ch.source)
    );

    always #2 clk = ~clk;

    logic [1:0]  oss_reg = 2'd3;
    logic [47:0] sa_reg = '0, ua_reg = '0, sm_reg = '0;
    logic [31:0] sb_reg = '0;

    reading_t pending_q[$];
    comp_t    expected_q[$];
    int  send_idle_pct = 0, recv_idle_pct = 0;
    int  fail_count = 0;
    longint cycle_count = 0;

    function automatic logic [31:0] shr_s(logic [31:0] v, int s);
        return $signed(v) >>> s;
    endfunction

    function automatic logic [31:0] div_s(logic [31:0] n, logic [31:0] d);
        longint q;
        q = longint'($signed(n)) / longint'($signed(d));
        return q[31:0];
    endfunction

    function automatic logic [31:0] ext16(logic [15:0] v);
        return {{16{v[15]}}, v};
    endfunction

    function automatic comp_t compensate(reading_t r);
        logic [31:0] a1, a2, a3, a4, a5, a6, b1, b2, mc, md;
        logic [31:0] up, x1, x2, x3, xx, b5, b6, b3, b4, b7, p, t, bb;
        comp_t c;
        a1 = ext16(sa_reg[15:0]);  a2 = ext16(sa_reg[31:16]); a3 = ext16(sa_reg[47:32]);
        a4 = {16'd0, ua_reg[15:0]}; a5 = {16'd0, ua_reg[31:16]};
        a6 = {16'd0, ua_reg[47:32]};
        b1 = ext16(sb_reg[15:0]);  b2 = ext16(sb_reg[31:16]);
        mc = ext16(sm_reg[31:16]); md = ext16(sm_reg[47:32]);
        up = (({16'd0, r.press_word} << 8) + {24'd0, r.xlsb}) >> (8 - oss_reg);
        x1 = shr_s(({16'd0, r.raw_temp} - a6) * a5, 15);
        xx = x1 + md;
        if (xx == 0)
        begin
            c.temp = K_T_FAIL;
            c.press = '0;
            c.status = ST_TEMP_DIV;
            return c;
        end
        x2 = div_s(mc << 11, xx);
        b5 = x1 + x2;
        t = shr_s(b5 + 32'd8, 4);
        b6 = b5 - 32'd4000;
        bb = shr_s(b6 * b6, 12);
        x1 = shr_s(b2 * bb, 11);
        x2 = shr_s(a2 * b6, 11);
        x3 = x1 + x2;
        b3 = shr_s(((a1 * 32'd4 + x3) << oss_reg) + 32'd2, 2);
        x1 = shr_s(a3 * b6, 13);
        x2 = shr_s(b1 * bb, 16);
        x3 = shr_s(x1 + x2 + 32'd2, 2);
        b4 = (a4 * (x3 + 32'd32768)) >> 15;
        c.status = ST_OK;
        if (b4 == 0)
        begin
            p = 32'hFFFF_FFFF;
            c.status = ST_PRES_DIV;
        end
        else
        begin
            b7 = (up - b3) * (32'd50000 >> oss_reg);
            if (b7 < 32'h8000_0000)
                p = (b7 << 1) / b4;
            else
                p = (b7 / b4) << 1;
            x1 = shr_s(p, 8) * shr_s(p, 8);
            x1 = shr_s(x1 * 32'd3038, 16);
            x2 = shr_s(32'd0 - 32'd7357 * p, 16);
            p = p + shr_s(x1 + x2 + 32'd3791, 4);
        end
        c.temp = t[15:0];
        c.press = p;
        return c;
    endfunction

    // driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_ch.valid <= 1'b0;
            in_ch.raw_temp <= '0;
            in_ch.raw_press_word <= '0;
            in_ch.raw_press_xlsb <= '0;
        end
        else if (!in_ch.valid || in_ch.ready)
        begin
            if (in_ch.valid)
                expected_q.push_back(compensate({in_ch.raw_temp, in_ch.raw_press_word,
                                                 in_ch.raw_press_xlsb}));
            if (pending_q.size() > 0 && $urandom_range(99) >= send_idle_pct)
            begin
                reading_t r;
                r = pending_q.pop_front();
                in_ch.valid <= 1'b1;
                in_ch.raw_temp <= r.raw_temp;
                in_ch.raw_press_word <= r.press_word;
                in_ch.raw_press_xlsb <= r.xlsb;
            end
            else
                in_ch.valid <= 1'b0;
        end
    end

    // monitor
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_ch.ready <= 1'b0;
        else
        begin
            if (out_ch.valid && out_ch.ready)
            begin
                if (expected_q.size() == 0)
                begin
                    $error("unexpected result transfer");
                    fail_count++;
                end
                else
                begin
                    comp_t e;
                    e = expected_q.pop_front();
                    if (out_ch.temp_tenths !== e.temp)
                    begin
                        $error("temp_tenths exp %0d got %0d", $signed(e.temp),
                               out_ch.temp_tenths);
                        fail_count++;
                    end
                    if (out_ch.pressure_pa !== e.press)
                    begin
                        $error("pressure_pa exp %0d got %0d", $signed(e.press),
                               out_ch.pressure_pa);
                        fail_count++;
                    end
                    if (out_ch.status !== e.status)
                    begin
                        $error("status exp %0d got %0d", e.status, out_ch.status);
                        fail_count++;
                    end
                end
            end
            out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > 400000)
        begin
            $display("TEST FAILED");
            $finish;
        end
    end

    task automatic drain();
        while (pending_q.size() > 0 || in_ch.valid || expected_q.size() > 0)
            @(negedge clk);
        repeat (100) @(posedge clk);
    endtask

    task automatic write_reg(logic [IDX_W-1:0] idx, logic [CFG_W-1:0] val);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        case (idx)
            CFG_OSS:      oss_reg = val[1:0];
            CFG_SIGNED_A: sa_reg = val[47:0];
            CFG_UNSIGN_A: ua_reg = val[47:0];
            CFG_SIGNED_B: sb_reg = val[31:0];
            default:      sm_reg = val[47:0];
        endcase
    endtask

    // typical calibration set, scrambled a little, or a fully random one when wild is set
    task automatic load_cal(bit wild);
        if (wild)
        begin
            write_reg(CFG_SIGNED_A, CFG_W'({$urandom(), $urandom()}));
            write_reg(CFG_UNSIGN_A, CFG_W'({$urandom(), $urandom()}));
            write_reg(CFG_SIGNED_B, CFG_W'($urandom()));
            write_reg(CFG_SIGNED_M, CFG_W'({$urandom(), $urandom()}));
        end
        else
        begin
            write_reg(CFG_SIGNED_A, {16'(-14383 + $urandom_range(400)),
                                     16'(-1100 - $urandom_range(200)),
                                     16'(408 + $urandom_range(8000))});
            write_reg(CFG_UNSIGN_A, {16'(23153 + $urandom_range(2000)),
                                     16'(32757 + $urandom_range(1000)),
                                     16'(32741 + $urandom_range(1000))});
            write_reg(CFG_SIGNED_B, CFG_W'({16'(4 + $urandom_range(40)),
                                            16'(6190 + $urandom_range(300))}));
            write_reg(CFG_SIGNED_M, {16'(2868 - $urandom_range(200)),
                                     16'(-8711 + $urandom_range(300)), 16'($urandom())});
        end
    endtask

    task automatic push_random(int n);
        reading_t r;
        repeat (n)
        begin
            if ($urandom_range(9) < 7)
            begin
                r.raw_temp = 16'(27898 + $urandom_range(4000) - 2000);
                r.press_word = 16'(23843 + $urandom_range(10000) - 5000);
            end
            else
            begin
                r.raw_temp = 16'($urandom());
                r.press_word = 16'($urandom());
            end
            r.xlsb = 8'($urandom());
            pending_q.push_back(r);
        end
    endtask

    initial
    begin
        in_ch.valid = 1'b0;
        in_ch.raw_temp = '0;
        in_ch.raw_press_word = '0;
        in_ch.raw_press_xlsb = '0;
        out_ch.ready = 1'b0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // reset calibration: md zero and a5 zero make the temperature divisor zero
        pending_q.push_back({16'd1234, 16'd5678, 8'd9});
        drain();

        // directed corners on a typical calibration
        load_cal(1'b0);
        for (int o = 0; o < 4; o++)
        begin
            write_reg(CFG_OSS, CFG_W'(o));
            pending_q.push_back({16'h0000, 16'h0000, 8'h00});
            pending_q.push_back({16'hFFFF, 16'hFFFF, 8'hFF});
            pending_q.push_back({16'd27898, 16'd23843, 8'hA5});
            pending_q.push_back({16'h8000, 16'h8000, 8'h5A});
            drain();
        end
        // pressure divisor zero: a4 zero
        write_reg(CFG_UNSIGN_A, {16'd32741, 16'd32757, 16'd0});
        pending_q.push_back({16'd27898, 16'd23843, 8'h11});
        pending_q.push_back({16'hFFFF, 16'h0000, 8'hFF});
        drain();
        // temperature divisor zero: a5 zero, md zero
        write_reg(CFG_UNSIGN_A, 48'd0);
        write_reg(CFG_SIGNED_M, {16'd0, 16'd2868, 16'd0});
        pending_q.push_back({16'd100, 16'd200, 8'h33});
        drain();

        for (int ph = 0; ph < 9; ph++)
        begin
            send_idle_pct = (ph < 3) ? 11 : (ph < 6) ? 74 : 0;
            recv_idle_pct = (ph < 3) ? 74 : (ph < 6) ? 11 : 0;
            load_cal(ph % 3 == 2);
            write_reg(CFG_OSS, CFG_W'($urandom_range(3)));
            push_random(150);
            drain();
        end

        if (fail_count == 0 && expected_q.size() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end
endmodule

[filelist.f]
hdl/bsc_pkg.sv
hdl/bsc_if.sv
hdl/bsc_div.sv
hdl/barometric_sensor_compensation.sv
test/tb_top.sv
